### rtl/core/mpft_pkg.sv
// Shared codes and constants for the monochrome page framebuffer text unit
`timescale 1ns / 1ps

package mpft_pkg;

  // operation codes carried in the func field
  localparam logic [2:0] FUNC_FILL    = 3'd0;
  localparam logic [2:0] FUNC_PIXEL   = 3'd1;
  localparam logic [2:0] FUNC_CHAR    = 3'd2;
  localparam logic [2:0] FUNC_READOUT = 3'd3;
  localparam logic [2:0] FUNC_STRING  = 3'd4;

  // glyph geometry
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;

  // printable character range
  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7E;

  // cursor movement
  localparam logic [7:0] CHAR_ADVANCE = 8'd6;
  localparam logic [7:0] LINE_ADVANCE = 8'd8;
  localparam logic [8:0] CHAR_SPAN    = 9'd5;

  // fill patterns
  localparam logic [7:0] FILL_WHITE = 8'hFF;
  localparam logic [7:0] FILL_BLACK = 8'h00;

  // longest readout burst
  localparam int MAX_RESULTS = 16;

endpackage

### rtl/core/mono_page_framebuffer_text_unit.sv
// Top level: page-organized monochrome frame store with 5x7 text drawing
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid / in_stall) takes one command item: fill, pixel,
// char, readout chunk or string character. Output channel (out_valid /
// out_stall) returns one item per command, or a burst of min(CHUNK_BYTES,16)
// items for a readout; last marks the final item of each command.
// One command is in flight at a time; in_stall is high while it runs.
// Steps per command, set by the single-port byte read-modify-write unit:
//   fill            one byte a cycle over the whole store, then the result
//   pixel, char     5 columns x 2 pages x read then write, plus result
//   string char     adds the cursor wrap step; unprintable codes skip drawing
//   readout         per byte: read, then load into the output register
//   unknown func    result only
// After reset the frame store is swept to zero, one byte a cycle, over all
// SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) bytes (1024 by default) while
// in_stall stays high; cursor and line start reset to zero.
// A result waits in the output register while out_stall is high; the block
// goes back to idle and may take the next command meanwhile, but it holds
// before loading a further result until the waiting one is taken.
module mono_page_framebuffer_text_unit #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int CHUNK_BYTES   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  input  logic        color,
  input  logic [7:0]  char_code,
  input  logic [34:0] glyph_bits,
  input  logic        new_string,
  input  logic [5:0]  chunk_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic [7:0]  next_x,
  output logic        last
);

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int NRES        = (CHUNK_BYTES > mpft_pkg::MAX_RESULTS) ?
                               mpft_pkg::MAX_RESULTS : CHUNK_BYTES;
  localparam int KW          = (NRES > 1) ? $clog2(NRES) : 1;
  localparam int RDW         = $clog2(64 * CHUNK_BYTES);
  localparam int IW          = 14;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_WRAP,
    ST_RD_REQ,
    ST_RD_DATA,
    ST_RESULT
  } state_t;

  state_t state;

  // frame store and its port signals
  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  // command registers
  logic [AW-1:0] clr_addr;
  logic [7:0]    fill_byte;
  logic          fill_reply;
  logic [7:0]    dx;
  logic [7:0]    dy;
  logic [34:0]   glyph_sh;
  logic          draw_color;
  logic [2:0]    col_cnt;
  logic          half;
  logic          is_str;
  logic [7:0]    res_nx;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_mask;
  logic [RDW-1:0] rd_base;
  logic [KW-1:0] rd_k;
  logic          rd_inrange;

  // string cursor
  logic [7:0]    cursor_x;
  logic [7:0]    cursor_y;
  logic [7:0]    line_start_x;

  // combinational helpers
  logic          in_accept;
  logic          out_free;
  logic          load_res;
  logic          printable;
  logic [7:0]    base_x;
  logic [7:0]    base_y;
  logic [4:0]    page;
  logic          x_ok;
  logic [15:0]   col_shift;
  logic [7:0]    sel_bits;
  logic [7:0]    row_ok;
  logic [7:0]    draw_mask;
  logic [IW-1:0] pix_idx;
  logic [RDW-1:0] rd_addr;
  logic          rd_ok;
  logic          rd_last;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign load_res  = out_free && (state == ST_RD_DATA || state == ST_RESULT);
  assign printable = (char_code >= mpft_pkg::CHAR_FIRST) &&
                     (char_code <= mpft_pkg::CHAR_LAST);
  assign base_x    = new_string ? pos_x : cursor_x;
  assign base_y    = new_string ? pos_y : cursor_y;

  // byte address and mask for one glyph column in one page
  always_comb begin
    page      = dy[7:3] + {4'd0, half};
    x_ok      = ({1'b0, dx} < 9'(SCREEN_WIDTH));
    col_shift = {9'd0, glyph_sh[6:0]} << dy[2:0];
    sel_bits  = half ? col_shift[15:8] : col_shift[7:0];
    for (int b = 0; b < 8; b++) begin
      row_ok[b] = ({1'b0, page, 3'(b)} < 9'(SCREEN_HEIGHT));
    end
    draw_mask = sel_bits & row_ok & {8{x_ok}};
    pix_idx   = IW'(dx) + IW'(page) * IW'(SCREEN_WIDTH);
  end

  // readout address
  assign rd_addr = rd_base + RDW'(rd_k);
  assign rd_ok   = (32'(rd_addr) < STORE_BYTES);
  assign rd_last = (rd_k == KW'(NRES - 1));

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = fill_byte;
    mem_re    = 1'b0;
    mem_raddr = AW'(rd_addr);
    unique case (state)
      ST_FILL: begin
        mem_we = 1'b1;
      end
      ST_DRAW_RD: begin
        mem_re    = (draw_mask != 8'd0);
        mem_raddr = pix_idx[AW-1:0];
      end
      ST_DRAW_WR: begin
        mem_we    = (wr_mask != 8'd0);
        mem_waddr = wr_addr;
        mem_wdata = draw_color ? (rd_data | wr_mask) : (rd_data & ~wr_mask);
      end
      ST_RD_REQ: begin
        mem_re = rd_ok;
      end
      default: begin
      end
    endcase
  end

  // frame store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL;
      clr_addr     <= '0;
      fill_byte    <= mpft_pkg::FILL_BLACK;
      fill_reply   <= 1'b0;
      cursor_x     <= 8'd0;
      cursor_y     <= 8'd0;
      line_start_x <= 8'd0;
      out_valid    <= 1'b0;
      col_cnt      <= 3'd0;
      half         <= 1'b0;
      rd_k         <= '0;
      is_str       <= 1'b0;
    end else begin
      // load a result, or drop the held one once taken
      if (load_res) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        // sweep every byte with the fill pattern
        ST_FILL: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(STORE_BYTES - 1)) begin
            state <= fill_reply ? ST_RESULT : ST_IDLE;
          end
        end

        // decode a new command
        ST_IDLE: begin
          if (in_accept) begin
            col_cnt    <= 3'd0;
            half       <= 1'b0;
            draw_color <= color;
            is_str     <= 1'b0;
            res_nx     <= 8'd0;
            unique case (func)
              mpft_pkg::FUNC_FILL: begin
                clr_addr   <= '0;
                fill_byte  <= color ? mpft_pkg::FILL_WHITE : mpft_pkg::FILL_BLACK;
                fill_reply <= 1'b1;
                state      <= ST_FILL;
              end
              mpft_pkg::FUNC_PIXEL: begin
                dx       <= pos_x;
                dy       <= pos_y;
                glyph_sh <= 35'd1;
                state    <= ST_DRAW_RD;
              end
              mpft_pkg::FUNC_CHAR: begin
                dx       <= pos_x;
                dy       <= pos_y;
                glyph_sh <= glyph_bits;
                res_nx   <= printable ? (pos_x + mpft_pkg::CHAR_ADVANCE) : pos_x;
                state    <= printable ? ST_DRAW_RD : ST_RESULT;
              end
              mpft_pkg::FUNC_READOUT: begin
                rd_base <= RDW'(chunk_index) * RDW'(CHUNK_BYTES);
                rd_k    <= '0;
                state   <= ST_RD_REQ;
              end
              mpft_pkg::FUNC_STRING: begin
                is_str   <= 1'b1;
                dx       <= base_x;
                dy       <= base_y;
                glyph_sh <= glyph_bits;
                cursor_x <= printable ? (base_x + mpft_pkg::CHAR_ADVANCE) : base_x;
                cursor_y <= base_y;
                if (new_string) begin
                  line_start_x <= pos_x;
                end
                state <= printable ? ST_DRAW_RD : ST_WRAP;
              end
              default: begin
                state <= ST_RESULT;
              end
            endcase
          end
        end

        // read the byte under one glyph column and page
        ST_DRAW_RD: begin
          wr_addr <= pix_idx[AW-1:0];
          wr_mask <= draw_mask;
          state   <= ST_DRAW_WR;
        end

        // write it back, then step page, then column
        ST_DRAW_WR: begin
          half <= !half;
          if (half) begin
            dx       <= dx + 8'd1;
            glyph_sh <= glyph_sh >> mpft_pkg::GLYPH_ROWS;
            col_cnt  <= col_cnt + 3'd1;
          end
          if (half && col_cnt == 3'(mpft_pkg::GLYPH_COLS - 1)) begin
            state <= is_str ? ST_WRAP : ST_RESULT;
          end else begin
            state <= ST_DRAW_RD;
          end
        end

        // wrap the cursor to the next text line if the next character would not fit
        ST_WRAP: begin
          if ({1'b0, cursor_x} + mpft_pkg::CHAR_SPAN > 9'(SCREEN_WIDTH)) begin
            cursor_x <= line_start_x;
            cursor_y <= cursor_y + mpft_pkg::LINE_ADVANCE;
          end
          state <= ST_RESULT;
        end

        // issue one readout byte
        ST_RD_REQ: begin
          rd_inrange <= rd_ok;
          state      <= ST_RD_DATA;
        end

        // hand the readout byte to the output register
        ST_RD_DATA: begin
          if (out_free) begin
            data_byte <= rd_inrange ? rd_data : 8'd0;
            next_x    <= 8'd0;
            last      <= rd_last;
            if (rd_last) begin
              state <= ST_IDLE;
            end else begin
              rd_k  <= rd_k + KW'(1);
              state <= ST_RD_REQ;
            end
          end
        end

        // single result of a non-readout command
        ST_RESULT: begin
          if (out_free) begin
            data_byte <= 8'd0;
            next_x    <= is_str ? cursor_x : res_nx;
            last      <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // the store is written only by the fill sweep or a draw write-back
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_FILL || state == ST_DRAW_WR))
    else $error("frame store written outside fill or draw");

  // every accepted command leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state != ST_IDLE))
    else $error("accepted command did not start");

  // a readout byte before the final one is never marked last
  a_readout_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_DATA && out_free && !rd_last) |=> (out_valid && !last))
    else $error("readout burst ended early");

  // the output only becomes valid from a result load
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_RD_DATA || $past(state) == ST_RESULT))
    else $error("output valid without a result");
`endif

endmodule
